### design/fdr_pkg.sv
// Shared types and helpers for the frame dirty rectangle block.
`default_nettype none
package fdr_pkg;

  localparam int PIXEL_W  = 32;
  localparam int SIZE_W   = 11;
  localparam int COORD_W  = 10;
  localparam int RESULT_W = 1 + 1 + COORD_W + COORD_W + SIZE_W + SIZE_W;
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  // Register indexes on the configuration port.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Input kinds carried in tuser.
  localparam logic CMD_PIXEL   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [SIZE_W-1:0]  size_t;

  // Control that travels with a word from the address stage to the compare stage.
  typedef struct packed {
    logic valid;
    logic restart;
    logic last_pixel;
  } fdr_ctl_t;

  typedef struct packed {
    logic               has_changes;
    logic               full_frame;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    size_t              rect_width;
    size_t              rect_height;
  } fdr_result_t;

  // A zero size acts as one, and a size beyond the maximum acts as the maximum.
  function automatic size_t eff_size(input size_t v, input int maxv);
    size_t r;
    r = v;
    if (v == '0) begin
      r = size_t'(1);
    end else if (int'(v) > maxv) begin
      r = size_t'(maxv);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/frame_dirty_rectangle.sv
// Frame dirty rectangle detector: top level with configuration registers and stream ports.
//
// Usage: pixels arrive on the s_axis channel in raster order, one word per pixel,
// tuser low; a word with tuser high is a restart and drops the frame in progress.
// Each pixel is compared with the same position of the previous frame held in an
// on-chip frame store and then written over it. After the last pixel of a frame,
// one word leaves on m_axis with the change flag, the full-frame flag and the
// bounding rectangle of all changed pixels. The first frame after reset, after a
// restart or after a write to frame_width or frame_height reports the full frame.
// Throughput: one pixel per clock, set by the single read and single write port
// of the frame store (read in the address stage, written back in the compare stage).
// After the address stage register, the last pixel sets the result register.
// Reset clears the position, trackers and output; the frame store is not cleared,
// so no clearing pass is needed. When m_axis stalls with a result waiting, pixels
// keep flowing until the next frame's last pixel reaches the compare stage; there
// s_axis_tready drops until the waiting word is taken.
`default_nettype none
module frame_dirty_rectangle #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [fdr_pkg::SIZE_W-1:0]   cfg_data,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [fdr_pkg::PIXEL_W-1:0]  s_axis_tdata,  // pixel
  input  wire logic                         s_axis_tuser,  // command
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // has_changes, full_frame, rect_x, rect_y, rect_width, rect_height, zero fill
  output logic [fdr_pkg::TDATA_W-1:0]       m_axis_tdata
);
  import fdr_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = CW + RW;

  size_t       frame_width;
  size_t       frame_height;
  size_t       width;
  size_t       height;
  logic        stall;
  logic        wr_en;
  logic [AW-1:0] rd_addr;
  fdr_ctl_t    ctl;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  pixel_t      pixel;
  pixel_t      prev_pixel;
  fdr_result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= size_t'(1024);
      frame_height <= size_t'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width         = eff_size(frame_width, MAX_WIDTH);
  assign height        = eff_size(frame_height, MAX_HEIGHT);
  assign s_axis_tready = !stall;

  fdr_addr_gen #(
    .CW(CW),
    .RW(RW)
  ) u_addr_gen (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_we),
    .in_valid   (s_axis_tvalid),
    .in_restart (s_axis_tuser == CMD_RESTART),
    .in_pixel   (s_axis_tdata),
    .width      (width),
    .height     (height),
    .stall      (stall),
    .rd_addr    (rd_addr),
    .ctl        (ctl),
    .col        (col),
    .row        (row),
    .pixel      (pixel)
  );

  fdr_frame_store #(
    .AW(AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_axis_tvalid && !stall),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr ({row, col}),
    .wr_data (pixel),
    .rd_data (prev_pixel)
  );

  fdr_tracker #(
    .CW(CW),
    .RW(RW)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_we),
    .ctl        (ctl),
    .col        (col),
    .row        (row),
    .pixel      (pixel),
    .prev_pixel (prev_pixel),
    .width      (width),
    .height     (height),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .result     (result),
    .stall      (stall),
    .wr_en      (wr_en)
  );

  assign m_axis_tdata = {
    (TDATA_W - RESULT_W)'(0),
    result.rect_height,
    result.rect_width,
    result.rect_y,
    result.rect_x,
    result.full_frame,
    result.has_changes
  };

endmodule
`default_nettype wire

### design/fdr_frame_store.sv
// Previous-frame pixel memory with a registered read and write forwarding.
`default_nettype none
module fdr_frame_store #(
  parameter int AW = 20
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire fdr_pkg::pixel_t wr_data,
  output fdr_pkg::pixel_t      rd_data
);
  import fdr_pkg::*;

  pixel_t mem [2**AW];
  pixel_t mem_q;
  pixel_t byp_data;
  logic   byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // A read that meets a write to the same entry returns the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : mem_q;

endmodule
`default_nettype wire

### design/fdr_addr_gen.sv
// Raster position counters and the register stage that feeds the compare stage.
`default_nettype none
module fdr_addr_gen #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_clear,
  input  wire logic            in_valid,
  input  wire logic            in_restart,
  input  wire fdr_pkg::pixel_t in_pixel,
  input  wire fdr_pkg::size_t  width,
  input  wire fdr_pkg::size_t  height,
  input  wire logic            stall,
  output logic [CW+RW-1:0]     rd_addr,
  output fdr_pkg::fdr_ctl_t    ctl,
  output logic [CW-1:0]        col,
  output logic [RW-1:0]        row,
  output fdr_pkg::pixel_t      pixel
);
  import fdr_pkg::*;

  localparam int CEW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int REW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic          accept;
  logic          last_col;
  logic          last_row;

  assign accept   = in_valid && !stall;
  assign last_col = (CEW'(col_count) + CEW'(1)) >= CEW'(width);
  assign last_row = (REW'(row_count) + REW'(1)) >= REW'(height);
  assign rd_addr  = {row_count, col_count};

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (in_restart) begin
        col_count <= '0;
        row_count <= '0;
      end else if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (!stall) begin
      ctl.valid      <= in_valid;
      ctl.restart    <= in_restart;
      ctl.last_pixel <= !in_restart && last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col   <= col_count;
      row   <= row_count;
      pixel <= in_pixel;
    end
  end

endmodule
`default_nettype wire

### design/fdr_tracker.sv
// Compare stage: change detection, bounding box trackers and the result register.
`default_nettype none
module fdr_tracker #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_clear,
  input  wire fdr_pkg::fdr_ctl_t ctl,
  input  wire logic [CW-1:0]     col,
  input  wire logic [RW-1:0]     row,
  input  wire fdr_pkg::pixel_t   pixel,
  input  wire fdr_pkg::pixel_t   prev_pixel,
  input  wire fdr_pkg::size_t    width,
  input  wire fdr_pkg::size_t    height,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output fdr_pkg::fdr_result_t   result,
  output logic                   stall,
  output logic                   wr_en
);
  import fdr_pkg::*;

  logic          need_full;
  logic          any_change;
  logic [CW-1:0] min_col, max_col, min_col_next, max_col_next;
  logic [RW-1:0] min_row, max_row, min_row_next, max_row_next;
  logic          diff;
  logic          go;
  logic [CW:0]   span_col;
  logic [RW:0]   span_row;
  fdr_result_t   result_next;

  assign stall = ctl.valid && ctl.last_pixel && out_valid && !out_ready;
  assign go    = ctl.valid && !stall;
  assign wr_en = go && !ctl.restart;
  assign diff  = !need_full && (prev_pixel != pixel);

  always_comb begin
    min_col_next = min_col;
    max_col_next = max_col;
    min_row_next = min_row;
    max_row_next = max_row;
    if (diff) begin
      if (!any_change || col < min_col) min_col_next = col;
      if (!any_change || col > max_col) max_col_next = col;
      if (!any_change || row < min_row) min_row_next = row;
      if (!any_change || row > max_row) max_row_next = row;
    end
  end

  assign span_col = {1'b0, max_col_next} - {1'b0, min_col_next} + (CW + 1)'(1);
  assign span_row = {1'b0, max_row_next} - {1'b0, min_row_next} + (RW + 1)'(1);

  always_comb begin
    result_next = '0;
    if (need_full) begin
      result_next.has_changes = 1'b1;
      result_next.full_frame  = 1'b1;
      result_next.rect_width  = width;
      result_next.rect_height = height;
    end else if (any_change || diff) begin
      result_next.has_changes = 1'b1;
      result_next.rect_x      = COORD_W'(min_col_next);
      result_next.rect_y      = COORD_W'(min_row_next);
      result_next.rect_width  = SIZE_W'(span_col);
      result_next.rect_height = SIZE_W'(span_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      any_change <= 1'b0;
      need_full  <= 1'b1;
    end else if (go) begin
      if (ctl.restart) begin
        any_change <= 1'b0;
        need_full  <= 1'b1;
      end else if (ctl.last_pixel) begin
        any_change <= 1'b0;
        need_full  <= 1'b0;
      end else if (diff) begin
        any_change <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && diff) begin
      min_col <= min_col_next;
      max_col <= max_col_next;
      min_row <= min_row_next;
      max_row <= max_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && !ctl.restart && ctl.last_pixel) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && !ctl.restart && ctl.last_pixel) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
